// ----- sv/bhx_pkg.sv -----
// ----------------------------------------------------------------------------
// bhx_pkg: shared types and constants for the BinHex character decoder
// Holds the alphabet table, status codes, phase codes and the front/back op.
// ----------------------------------------------------------------------------
package bhx_pkg;

  // 64-symbol alphabet, index 0 is the first character
  localparam logic [0:63][7:0] ALPHABET =
    "!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[`abcdefhijklmpqr";

  localparam logic [7:0]  CHAR_COLON  = 8'h3A;
  localparam logic [7:0]  CHAR_SPACE  = 8'h20;
  localparam logic [7:0]  CHAR_TAB    = 8'h09;
  localparam logic [7:0]  CHAR_CR     = 8'h0D;
  localparam logic [7:0]  RUN_MARKER  = 8'h90;
  localparam logic [7:0]  LAST_RESET  = 8'hFF;
  localparam logic [3:0]  POS_RESET   = 4'd10;
  localparam logic [3:0]  POS_SPLIT   = 4'd9;
  localparam logic [3:0]  GROUP_BITS  = 4'd6;
  localparam logic [3:0]  POS_ADVANCE = 4'd2;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_OK       = 3'd1,
    ST_BADCHAR  = 3'd2,
    ST_EOF      = 3'd3,
    ST_NOSTART  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_SEEK   = 2'd0,
    PH_DECODE = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef enum logic {
    OP_SYM = 1'b0,
    OP_END = 1'b1
  } op_kind_e;

  // request passed from the front to the back
  typedef struct packed {
    op_kind_e   kind;
    logic [5:0] sym;
    status_e    status;
  } op_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

// ----- sv/bhx_front.sv -----
// ----------------------------------------------------------------------------
// bhx_front: character classifier
// Tracks the start/decode/done phase and turns each character into an op.
// ----------------------------------------------------------------------------
module bhx_front import bhx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_input_i,
  output logic       op_valid_o,
  output op_t        op_o
);

  phase_e     phase_q, phase_d;
  logic       hit;
  logic [5:0] sym;
  logic       blank;
  logic       colon;

  // alphabet search: 64 independent compares
  always_comb begin
    hit = 1'b0;
    sym = '0;
    for (int i = 0; i < 64; i++) begin
      if (ALPHABET[i] == in_char_i) begin
        hit = 1'b1;
        sym = 6'(i);
      end
    end
  end

  assign blank = is_blank(in_char_i);
  assign colon = (in_char_i == CHAR_COLON);

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_SEEK: begin
        if (end_of_input_i)  phase_d = PH_DONE;
        else if (blank)      phase_d = PH_SEEK;
        else if (colon)      phase_d = PH_DECODE;
        else                 phase_d = PH_DONE;
      end
      PH_DECODE: begin
        if (end_of_input_i)          phase_d = PH_DONE;
        else if (!blank && !hit)     phase_d = PH_DONE;
      end
      PH_DONE:  phase_d = PH_DONE;
      default:  phase_d = PH_DONE;
    endcase
  end

  // op generation
  always_comb begin
    op_valid_o  = 1'b0;
    op_o.kind   = OP_END;
    op_o.sym    = sym;
    op_o.status = ST_RUN;
    case (phase_q)
      PH_SEEK: begin
        if (end_of_input_i || (!blank && !colon)) begin
          op_valid_o  = 1'b1;
          op_o.status = ST_NOSTART;
        end
      end
      PH_DECODE: begin
        if (end_of_input_i) begin
          op_valid_o  = 1'b1;
          op_o.status = ST_EOF;
        end else if (hit) begin
          op_valid_o = 1'b1;
          op_o.kind  = OP_SYM;
        end else if (!blank) begin
          op_valid_o  = 1'b1;
          op_o.status = colon ? ST_OK : ST_BADCHAR;
        end
      end
      PH_DONE: op_valid_o = 1'b0;
      default: op_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ----- sv/bhx_fifo.sv -----
// ----------------------------------------------------------------------------
// bhx_fifo: two-entry op queue
// Decouples the classifier from the byte assembler.
// ----------------------------------------------------------------------------
module bhx_fifo import bhx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  op_t  wr_op_i,
  output logic full_o,
  output logic rd_valid_o,
  input  logic rd_i,
  output op_t  rd_op_o
);

  op_t        mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_wr, do_rd;

  assign full_o     = (count_q == 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_op_o    = mem_q[rd_ptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && rd_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd)      count_d = count_q + 2'd1;
    else if (!do_wr && do_rd) count_d = count_q - 2'd1;
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

endmodule

// ----- sv/bhx_back.sv -----
// ----------------------------------------------------------------------------
// bhx_back: byte assembler and run-length stage
// Packs 6-bit groups into bytes, applies the 0x90 run rule, holds the result.
// ----------------------------------------------------------------------------
module bhx_back import bhx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_take_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic [7:0] copy_count_o,
  output status_e    status_o
);

  logic [15:0] acc_q, acc_d, acc_or;
  logic [3:0]  pos_q, pos_d;
  logic        marker_q, marker_d;
  logic [7:0]  last_q, last_d;
  logic        res_valid_q;
  logic [7:0]  res_byte_q, res_byte_d;
  logic [7:0]  res_count_q, res_count_d;
  status_e     res_status_q, res_status_d;
  logic        emit;
  logic [7:0]  d;
  logic        free;

  // result register drains on pop; take an op when it is free
  assign free      = !res_valid_q || pop_i;
  assign op_take_o = op_valid_i && free;

  assign acc_or = acc_q | ({10'd0, op_i.sym} << pos_q);
  assign d      = acc_or[15:8];

  // assembler and run stage
  always_comb begin
    acc_d        = acc_q;
    pos_d        = pos_q;
    marker_d     = marker_q;
    last_d       = last_q;
    emit         = 1'b0;
    res_byte_d   = '0;
    res_count_d  = '0;
    res_status_d = ST_RUN;
    case (op_i.kind)
      OP_END: begin
        emit         = 1'b1;
        res_status_d = op_i.status;
      end
      OP_SYM: begin
        if (pos_q >= POS_SPLIT) begin
          acc_d = acc_or;
          pos_d = pos_q - GROUP_BITS;
        end else begin
          acc_d = {acc_or[7:0], 8'h00};
          pos_d = pos_q + POS_ADVANCE;
          if (marker_q) begin
            marker_d = 1'b0;
            if (d == 8'd0) begin
              emit        = 1'b1;
              res_byte_d  = RUN_MARKER;
              res_count_d = 8'd1;
              last_d      = RUN_MARKER;
            end else if (d != 8'd1) begin
              emit        = 1'b1;
              res_byte_d  = last_q;
              res_count_d = d - 8'd1;
            end
          end else if (d == RUN_MARKER) begin
            marker_d = 1'b1;
          end else begin
            emit        = 1'b1;
            res_byte_d  = d;
            res_count_d = 8'd1;
            last_d      = d;
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pos_q       <= POS_RESET;
      marker_q    <= 1'b0;
      last_q      <= LAST_RESET;
      res_valid_q <= 1'b0;
    end else begin
      if (op_take_o) begin
        acc_q    <= acc_d;
        pos_q    <= pos_d;
        marker_q <= marker_d;
        last_q   <= last_d;
      end
      if (free) res_valid_q <= op_take_o && emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (op_take_o && emit) begin
      res_byte_q   <= res_byte_d;
      res_count_q  <= res_count_d;
      res_status_q <= res_status_d;
    end
  end

  assign empty_o      = !res_valid_q;
  assign out_byte_o   = res_byte_q;
  assign copy_count_o = res_count_q;
  assign status_o     = res_status_q;

endmodule

// ----- sv/binhex_char_decoder.sv -----
// ----------------------------------------------------------------------------
// binhex_char_decoder: BinHex 4.0 character decoder with 0x90 run stage
// Top level: classifier, op queue and byte assembler.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive in_char_i / end_of_input_i and
//   raise push; the character is taken at an edge where push is high and
//   full is low. Output side is a queue read port: while empty is low the
//   oldest result sits on out_byte_o / copy_count_o / status_o and is taken
//   at an edge where pop is high.
//   Each character that yields a result has its op written into the op
//   queue at the accepting edge; the assembler then takes the op and loads
//   the result register once that register is free or being popped. One
//   character per cycle is sustained while the reader keeps up.
//   Blanks, the start colon and the first group of each four-group set give no result.
//   When the reader stalls, the result register holds, the two-entry op
//   queue fills and full rises; no item is lost or repeated.
//   After a result with a nonzero status, no further results appear.
//   Reset clears the queue and result register and returns the decoder to
//   searching for the start colon, at once.
// ----------------------------------------------------------------------------
module binhex_char_decoder import bhx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       end_of_input_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [7:0] copy_count_o,
  output logic [2:0] status_o
);

  logic    accept;
  logic    fr_valid;
  op_t     fr_op;
  logic    q_valid;
  op_t     q_op;
  logic    q_take;
  status_e status;

  assign accept   = push && !full;
  assign status_o = status;

  bhx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_char_i      (in_char_i),
    .end_of_input_i (end_of_input_i),
    .op_valid_o     (fr_valid),
    .op_o           (fr_op)
  );

  bhx_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept && fr_valid),
    .wr_op_i    (fr_op),
    .full_o     (full),
    .rd_valid_o (q_valid),
    .rd_i       (q_take),
    .rd_op_o    (q_op)
  );

  bhx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (q_valid),
    .op_i         (q_op),
    .op_take_o    (q_take),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .copy_count_o (copy_count_o),
    .status_o     (status)
  );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the BinHex character decoder
// Feeds one BinHex character stream: a directed table first (blanks, start
// colon, run marker cases, all-zero and all-one groups), then random encoded
// payload with sprinkled blanks, a broken tail group, a random way of ending
// and trailing noise. Every popped result is checked against a table row or a local model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bhx_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_SYMBOLS = 350;
  localparam int HOLD_CYCLES = 80;

  // alphabet, first symbol in the top byte
  localparam bit [8*64-1:0] SYMBOLS =
    "!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[`abcdefhijklmpqr";

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
    status_e    st;
  } result_t;

  // one character request; typed rows carry their own expected result
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    logic       has;
    result_t    res;
  } char_req_t;

  localparam result_t NO_RES = '{8'h00, 8'h00, ST_RUN};

  localparam char_req_t DIRECTED_REQS [0:27] = '{
    // blanks while seeking, then the start colon
    '{8'h20, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h09, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h0A, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h0B, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h0C, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h0D, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h3A, 1'b0, 1'b1, 1'b0, NO_RES},
    // bytes 90 03 90: run before any byte repeats 255
    '{8'h4E, 1'b0, 1'b1, 1'b0, NO_RES},                         // N
    '{8'h21, 1'b0, 1'b1, 1'b0, NO_RES},                         // !
    '{8'h31, 1'b0, 1'b1, 1'b1, '{8'hFF, 8'd2, ST_RUN}},          // 1
    '{8'h0D, 1'b0, 1'b1, 1'b0, NO_RES},                         // blank mid-group
    '{8'h33, 1'b0, 1'b0, 1'b0, NO_RES},                         // 3
    // bytes 00 90 01: literal marker, then a run of count zero
    '{8'h21, 1'b0, 1'b0, 1'b0, NO_RES},                         // !
    '{8'h2A, 1'b0, 1'b1, 1'b1, '{8'h90, 8'd1, ST_RUN}},          // *
    '{8'h21, 1'b0, 1'b0, 1'b0, NO_RES},                         // !
    '{8'h22, 1'b0, 1'b0, 1'b0, NO_RES},                         // "
    // all-zero group
    '{8'h21, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h21, 1'b0, 1'b1, 1'b1, '{8'h00, 8'd1, ST_RUN}},
    '{8'h21, 1'b0, 1'b1, 1'b1, '{8'h00, 8'd1, ST_RUN}},
    '{8'h21, 1'b0, 1'b1, 1'b1, '{8'h00, 8'd1, ST_RUN}},
    // all-one group
    '{8'h72, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h72, 1'b0, 1'b1, 1'b1, '{8'hFF, 8'd1, ST_RUN}},
    '{8'h72, 1'b0, 1'b1, 1'b1, '{8'hFF, 8'd1, ST_RUN}},
    '{8'h72, 1'b0, 1'b1, 1'b1, '{8'hFF, 8'd1, ST_RUN}},
    // bytes 41 90 FF: longest run
    '{8'h33, 1'b0, 1'b0, 1'b0, NO_RES},                         // 3
    '{8'h43, 1'b0, 1'b0, 1'b0, NO_RES},                         // C
    '{8'h24, 1'b0, 1'b0, 1'b0, NO_RES},                         // $
    '{8'h72, 1'b0, 1'b0, 1'b0, NO_RES}                          // r
  };

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_char_i;
  logic       end_of_input_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic [7:0] copy_count_o;
  logic [2:0] status_o;

  binhex_char_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_char_i      (in_char_i),
    .end_of_input_i (end_of_input_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .copy_count_o   (copy_count_o),
    .status_o       (status_o)
  );

  // decoder model state, at its reset values
  phase_e      dec_phase   = PH_SEEK;
  logic [15:0] acc_bits    = 16'h0000;
  logic [3:0]  shift_pos   = 4'd10;
  logic        run_pending = 1'b0;
  logic [7:0]  prev_byte   = 8'hFF;

  result_t     decoded_q [$];
  logic [7:0]  pending_bytes [$];
  int          mismatches = 0;
  int          send_idle = 26;
  int          recv_idle = 67;
  bit          stall_reader = 1'b0;

  function automatic bit is_gap(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit symbol_of(input logic [7:0] c, output logic [5:0] idx);
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (SYMBOLS[8*(63-i) +: 8] == c) begin
        idx = 6'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // advance the model by one character; returns 1 when a result is due
  function automatic bit decode_char(input logic [7:0] c, input logic e, output result_t r);
    logic [5:0]  v;
    logic [15:0] acc;
    logic [7:0]  d;
    int          pos;
    r = NO_RES;
    if (dec_phase == PH_DONE) return 1'b0;
    if (dec_phase == PH_SEEK) begin
      if (!e && is_gap(c)) return 1'b0;
      if (!e && c == CHAR_COLON) begin
        dec_phase = PH_DECODE;
        return 1'b0;
      end
      dec_phase = PH_DONE;
      r.st = ST_NOSTART;
      return 1'b1;
    end
    if (e) begin
      dec_phase = PH_DONE;
      r.st = ST_EOF;
      return 1'b1;
    end
    if (is_gap(c)) return 1'b0;
    if (!symbol_of(c, v)) begin
      dec_phase = PH_DONE;
      r.st = (c == CHAR_COLON) ? ST_OK : ST_BADCHAR;
      return 1'b1;
    end
    acc = acc_bits | (16'(v) << shift_pos);
    pos = int'(shift_pos) - 6;
    if (pos > 2) begin
      acc_bits = acc;
      shift_pos = 4'(pos);
      return 1'b0;
    end
    d = acc[15:8];
    acc_bits = {acc[7:0], 8'h00};
    shift_pos = 4'(pos + 8);
    // run-length stage
    if (run_pending) begin
      run_pending = 1'b0;
      if (d == 8'h00) begin
        prev_byte = RUN_MARKER;
        r.value = RUN_MARKER;
        r.count = 8'd1;
        return 1'b1;
      end
      if (d == 8'h01) return 1'b0;
      r.value = prev_byte;
      r.count = d - 8'd1;
      return 1'b1;
    end
    if (d == RUN_MARKER) begin
      run_pending = 1'b1;
      return 1'b0;
    end
    prev_byte = d;
    r.value = d;
    r.count = 8'd1;
    return 1'b1;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // present one request at a falling edge, hold it until taken
  task automatic offer(input char_req_t rq);
    result_t r;
    bit      got;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push           <= 1'b1;
    in_char_i      <= rq.ch;
    end_of_input_i <= rq.eoi;
    do @(posedge clk_i); while (full);
    got = decode_char(rq.ch, rq.eoi, r);
    if (rq.typed) begin
      if (rq.has) decoded_q.push_back(rq.res);
    end else if (got) begin
      decoded_q.push_back(r);
    end
    @(negedge clk_i);
  endtask

  // append random payload bytes, marker runs included
  task automatic queue_payload();
    int kind;
    int sel;
    kind = $urandom_range(99);
    if (kind < 70) begin
      pending_bytes.push_back(8'($urandom_range(255)));
    end else begin
      if (kind >= 90) pending_bytes.push_back(8'($urandom_range(255)));
      pending_bytes.push_back(RUN_MARKER);
      sel = $urandom_range(4);
      case (sel)
        0: pending_bytes.push_back(8'h00);
        1: pending_bytes.push_back(8'h01);
        2: pending_bytes.push_back(8'h02);
        3: pending_bytes.push_back(8'hFF);
        default: pending_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  function automatic logic [7:0] pick_gap();
    if ($urandom_range(6) == 6) return 8'h20;
    return 8'(8'h09 + $urandom_range(4));
  endfunction

  // encode payload three bytes at a time into four symbols
  task automatic send_symbols(input int count);
    int          sent;
    logic [23:0] word;
    logic [5:0]  grp;
    sent = 0;
    while (sent < count) begin
      while (pending_bytes.size() < 3) queue_payload();
      word = {pending_bytes.pop_front(), pending_bytes.pop_front(), pending_bytes.pop_front()};
      for (int g = 0; g < 4; g++) begin
        grp = word[23-6*g -: 6];
        if ($urandom_range(99) < 6) offer('{pick_gap(), 1'b0, 1'b0, 1'b0, NO_RES});
        offer('{SYMBOLS[8*(63-int'(grp)) +: 8], 1'b0, 1'b0, 1'b0, NO_RES});
      end
      sent += 4;
    end
  endtask

  // reader: random pop, one long hold-off on request
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_reader) begin
        stall_reader = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic note_mismatch(input string field, input int want, input int act);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, act);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h/%0d/%0d",
                 $time, out_byte_o, copy_count_o, status_o);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.value)
          note_mismatch("out_byte", want.value, out_byte_o);
        if (copy_count_o !== want.count)
          note_mismatch("copy_count", want.count, copy_count_o);
        if (status_o !== want.st)
          note_mismatch("status", int'(want.st), status_o);
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] c;
    logic [5:0] idx;
    int         tail;
    rst_ni         <= 1'b0;
    push           <= 1'b0;
    in_char_i      <= 8'h00;
    end_of_input_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, then first random phase
    foreach (DIRECTED_REQS[i]) offer(DIRECTED_REQS[i]);
    send_symbols(PHASE_SYMBOLS);

    send_idle = 67;
    recv_idle = 26;
    send_symbols(PHASE_SYMBOLS);

    // no idling; reader holds off so the input backs up
    send_idle = 0;
    recv_idle = 0;
    stall_reader = 1'b1;
    send_symbols(PHASE_SYMBOLS);

    // broken last group
    tail = $urandom_range(3);
    repeat (tail) offer('{SYMBOLS[8*$urandom_range(63) +: 8], 1'b0, 1'b0, 1'b0, NO_RES});

    // end of decoding: closing colon, bad character or end of input
    case ($urandom_range(2))
      0: offer('{CHAR_COLON, 1'b0, 1'b0, 1'b0, NO_RES});
      1: begin
        do c = 8'($urandom_range(255));
        while (symbol_of(c, idx) || is_gap(c) || c == CHAR_COLON);
        offer('{c, 1'b0, 1'b0, 1'b0, NO_RES});
      end
      default: offer('{8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, NO_RES});
    endcase

    // anything after the end gives nothing
    repeat (24) offer('{8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 1'b0, NO_RES});
    push <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bhx_pkg.sv
sv/bhx_front.sv
sv/bhx_fifo.sv
sv/bhx_back.sv
sv/binhex_char_decoder.sv
bench/tb.sv
